>>> rtl/core/sca_pkg.sv
// ----------------------------------------------------------------------------
// Size count agent transition package
// Shared widths, configuration register indexes, reset values and the
// configuration word type.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int TIME_BITS_DEF     = 21;
    localparam int ESTIMATE_BITS_DEF = 12;
    localparam int COUNT_BITS        = 20;
    localparam int DRAW_BITS         = 7;
    localparam int MULT_BITS         = 8;
    localparam int OVER_BITS         = 4;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RESET_TIME   = 3'd0,
        CFG_HEALTHY_TIME = 3'd1,
        CFG_ADOPT_TIME   = 3'd2,
        CFG_INTERACTION  = 3'd3,
        CFG_OVERESTIMATE = 3'd4
    } cfg_index_t;

    localparam logic [MULT_BITS-1:0] RESET_TIME_RST   = 8'd8;
    localparam logic [MULT_BITS-1:0] HEALTHY_TIME_RST = 8'd4;
    localparam logic [MULT_BITS-1:0] ADOPT_TIME_RST   = 8'd2;
    localparam logic [MULT_BITS-1:0] INTERACTION_RST  = 8'd16;
    localparam logic [OVER_BITS-1:0] OVERESTIMATE_RST = 4'd2;

    typedef struct packed {
        logic [MULT_BITS-1:0] reset_time;
        logic [MULT_BITS-1:0] healthy_time;
        logic [MULT_BITS-1:0] adopt_time;
        logic [MULT_BITS-1:0] interaction;
        logic [OVER_BITS-1:0] overestimate;
    } cfg_t;

endpackage

>>> rtl/core/sca_cfg_regs.sv
// ----------------------------------------------------------------------------
// Size count agent transition configuration registers
// Holds the five multipliers and takes one register write per cycle.
// ----------------------------------------------------------------------------
module sca_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sca_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output sca_pkg::cfg_t                      cfg
);
    import sca_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_TIME:   cfg_next.reset_time   = cfg_data;
                CFG_HEALTHY_TIME: cfg_next.healthy_time = cfg_data;
                CFG_ADOPT_TIME:   cfg_next.adopt_time   = cfg_data;
                CFG_INTERACTION:  cfg_next.interaction  = cfg_data;
                CFG_OVERESTIMATE: cfg_next.overestimate = cfg_data[OVER_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_time   <= RESET_TIME_RST;
            cfg_reg.healthy_time <= HEALTHY_TIME_RST;
            cfg_reg.adopt_time   <= ADOPT_TIME_RST;
            cfg_reg.interaction  <= INTERACTION_RST;
            cfg_reg.overestimate <= OVERESTIMATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/sca_front.sv
// ----------------------------------------------------------------------------
// Size count agent transition front pipeline
// Three stages: threshold products and scaled draws, the timeout or mismatch
// resample, and the periodic resample.
// ----------------------------------------------------------------------------
module sca_front #(
    parameter int TIME_BITS     = sca_pkg::TIME_BITS_DEF,
    parameter int ESTIMATE_BITS = sca_pkg::ESTIMATE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sca_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    input  logic [TIME_BITS-1:0]                 own_time,
    input  logic [ESTIMATE_BITS-1:0]             own_estimate,
    input  logic [ESTIMATE_BITS-1:0]             own_last_estimate,
    input  logic [sca_pkg::COUNT_BITS-1:0]       own_count,
    input  logic [TIME_BITS-1:0]                 peer_time,
    input  logic [ESTIMATE_BITS-1:0]             peer_estimate,
    input  logic [ESTIMATE_BITS-1:0]             peer_last_estimate,
    input  logic [sca_pkg::DRAW_BITS-1:0]        first_draw,
    input  logic [sca_pkg::DRAW_BITS-1:0]        second_draw,
    output logic                                 out_valid,
    output logic [TIME_BITS-1:0]                 out_time,
    output logic [ESTIMATE_BITS-1:0]             out_estimate,
    output logic [ESTIMATE_BITS-1:0]             out_last_estimate,
    output logic [sca_pkg::COUNT_BITS-1:0]       out_count,
    output logic [TIME_BITS-1:0]                 out_peer_time,
    output logic [ESTIMATE_BITS-1:0]             out_peer_estimate,
    output logic [ESTIMATE_BITS-1:0]             out_peer_last_estimate,
    output logic [sca_pkg::MULT_BITS+ESTIMATE_BITS-1:0] out_t2_peer,
    output logic [sca_pkg::MULT_BITS+ESTIMATE_BITS-1:0] out_t3_peer,
    output logic [TIME_BITS-1:0]                 out_t3_peer_sat
);
    import sca_pkg::*;

    localparam int PB = MULT_BITS + ESTIMATE_BITS;
    localparam int CW = ((TIME_BITS > PB) ? TIME_BITS : PB) + 2;
    localparam int SB = DRAW_BITS + OVER_BITS;
    localparam int SW = (SB > ESTIMATE_BITS) ? SB : ESTIMATE_BITS;
    localparam int DW = (DRAW_BITS > ESTIMATE_BITS) ? DRAW_BITS : ESTIMATE_BITS;
    localparam int KW = (COUNT_BITS > PB) ? COUNT_BITS : PB;

    function automatic logic signed [CW-1:0] sx_time(input logic [TIME_BITS-1:0] t);
        sx_time = {{(CW-TIME_BITS){t[TIME_BITS-1]}}, t};
    endfunction

    function automatic logic signed [CW-1:0] zx_prod(input logic [PB-1:0] p);
        zx_prod = {{(CW-PB){1'b0}}, p};
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_prod(input logic [PB-1:0] p);
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] lim;
        w   = zx_prod(p);
        lim = {{(CW-TIME_BITS+1){1'b0}}, {(TIME_BITS-1){1'b1}}};
        sat_prod = (w > lim) ? lim[TIME_BITS-1:0] : w[TIME_BITS-1:0];
    endfunction

    function automatic logic [ESTIMATE_BITS-1:0] scale_draw(
        input logic [DRAW_BITS-1:0] d,
        input logic [OVER_BITS-1:0] f
    );
        logic [SB-1:0] p;
        logic [SW-1:0] w;
        logic [SW-1:0] emax;
        p    = SB'(d) * SB'(f);
        w    = SW'(p);
        emax = SW'({ESTIMATE_BITS{1'b1}});
        scale_draw = (w > emax) ? emax[ESTIMATE_BITS-1:0] : w[ESTIMATE_BITS-1:0];
    endfunction

    // Stage 1.
    logic                     s1_valid_reg;
    logic [TIME_BITS-1:0]     s1_time_reg;
    logic [ESTIMATE_BITS-1:0] s1_est_reg;
    logic [ESTIMATE_BITS-1:0] s1_last_reg;
    logic [COUNT_BITS-1:0]    s1_count_reg;
    logic [TIME_BITS-1:0]     s1_peer_time_reg;
    logic [ESTIMATE_BITS-1:0] s1_peer_est_reg;
    logic [ESTIMATE_BITS-1:0] s1_peer_last_reg;
    logic [DRAW_BITS-1:0]     s1_draw2_reg;
    logic [ESTIMATE_BITS-1:0] s1_draw1_est_reg;
    logic [ESTIMATE_BITS-1:0] s1_draw2_est_reg;
    logic [PB-1:0]            s1_t2_own_reg;
    logic [PB-1:0]            s1_t3_own_reg;
    logic [PB-1:0]            s1_t2_peer_reg;
    logic [PB-1:0]            s1_t3_peer_reg;
    logic [ESTIMATE_BITS-1:0] s1_draw1_est_next;
    logic [ESTIMATE_BITS-1:0] s1_draw2_est_next;
    logic [PB-1:0]            s1_t2_own_next;
    logic [PB-1:0]            s1_t3_own_next;
    logic [PB-1:0]            s1_t2_peer_next;
    logic [PB-1:0]            s1_t3_peer_next;

    always_comb
    begin
        s1_draw1_est_next = scale_draw(first_draw, cfg.overestimate);
        s1_draw2_est_next = scale_draw(second_draw, cfg.overestimate);
        s1_t2_own_next    = PB'(cfg.healthy_time) * PB'(own_estimate);
        s1_t3_own_next    = PB'(cfg.adopt_time) * PB'(own_estimate);
        s1_t2_peer_next   = PB'(cfg.healthy_time) * PB'(peer_estimate);
        s1_t3_peer_next   = PB'(cfg.adopt_time) * PB'(peer_estimate);
    end

    always_ff @(posedge clk)
    begin
        s1_time_reg      <= own_time;
        s1_est_reg       <= own_estimate;
        s1_last_reg      <= own_last_estimate;
        s1_count_reg     <= own_count;
        s1_peer_time_reg <= peer_time;
        s1_peer_est_reg  <= peer_estimate;
        s1_peer_last_reg <= peer_last_estimate;
        s1_draw2_reg     <= second_draw;
        s1_draw1_est_reg <= s1_draw1_est_next;
        s1_draw2_est_reg <= s1_draw2_est_next;
        s1_t2_own_reg    <= s1_t2_own_next;
        s1_t3_own_reg    <= s1_t3_own_next;
        s1_t2_peer_reg   <= s1_t2_peer_next;
        s1_t3_peer_reg   <= s1_t3_peer_next;
    end

    // Stage 2.
    logic                     s2_valid_reg;
    logic                     s2_resample_reg;
    logic [TIME_BITS-1:0]     s2_time_reg;
    logic [ESTIMATE_BITS-1:0] s2_est_reg;
    logic [ESTIMATE_BITS-1:0] s2_last_reg;
    logic [COUNT_BITS-1:0]    s2_count_reg;
    logic [ESTIMATE_BITS-1:0] s2_big_reg;
    logic [TIME_BITS-1:0]     s2_peer_time_reg;
    logic [ESTIMATE_BITS-1:0] s2_peer_est_reg;
    logic [ESTIMATE_BITS-1:0] s2_peer_last_reg;
    logic [DRAW_BITS-1:0]     s2_draw2_reg;
    logic [ESTIMATE_BITS-1:0] s2_draw2_est_reg;
    logic [PB-1:0]            s2_t1_draw2_reg;
    logic [PB-1:0]            s2_t2_peer_reg;
    logic [PB-1:0]            s2_t3_peer_reg;
    logic [TIME_BITS-1:0]     s2_t3_peer_sat_reg;
    logic                     s2_resample_next;
    logic [ESTIMATE_BITS-1:0] s2_est_next;
    logic [ESTIMATE_BITS-1:0] s2_last_next;
    logic [COUNT_BITS-1:0]    s2_count_next;
    logic [ESTIMATE_BITS-1:0] s2_big_next;
    logic [PB-1:0]            s2_t1_draw2_next;
    logic [TIME_BITS-1:0]     s2_t3_peer_sat_next;
    logic signed [CW-1:0]     s1_ut;
    logic signed [CW-1:0]     s1_vt;

    always_comb
    begin
        s1_ut = sx_time(s1_time_reg);
        s1_vt = sx_time(s1_peer_time_reg);
        s2_resample_next = s1_time_reg[TIME_BITS-1] || (s1_time_reg == '0)
            || ((s1_ut <= zx_prod(s1_t3_own_reg)) && (s1_vt > zx_prod(s1_t2_peer_reg)))
            || ((s1_ut < zx_prod(s1_t2_own_reg)) && (s1_est_reg != s1_peer_est_reg));
        s2_est_next   = s2_resample_next ? s1_draw1_est_reg : s1_est_reg;
        s2_last_next  = s2_resample_next ? s1_est_reg : s1_last_reg;
        s2_count_next = s2_resample_next ? '0 : s1_count_reg;
        s2_big_next   = (s2_est_next < s2_last_next) ? s2_last_next : s2_est_next;
        s2_t1_draw2_next    = PB'(cfg.reset_time) * PB'(s1_draw2_est_reg);
        s2_t3_peer_sat_next = sat_prod(s1_t3_peer_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_resample_reg    <= s2_resample_next;
        s2_time_reg        <= s1_time_reg;
        s2_est_reg         <= s2_est_next;
        s2_last_reg        <= s2_last_next;
        s2_count_reg       <= s2_count_next;
        s2_big_reg         <= s2_big_next;
        s2_peer_time_reg   <= s1_peer_time_reg;
        s2_peer_est_reg    <= s1_peer_est_reg;
        s2_peer_last_reg   <= s1_peer_last_reg;
        s2_draw2_reg       <= s1_draw2_reg;
        s2_draw2_est_reg   <= s1_draw2_est_reg;
        s2_t1_draw2_reg    <= s2_t1_draw2_next;
        s2_t2_peer_reg     <= s1_t2_peer_reg;
        s2_t3_peer_reg     <= s1_t3_peer_reg;
        s2_t3_peer_sat_reg <= s2_t3_peer_sat_next;
    end

    // Stage 3.
    logic                     s3_valid_reg;
    logic [TIME_BITS-1:0]     s3_time_reg;
    logic [ESTIMATE_BITS-1:0] s3_est_reg;
    logic [ESTIMATE_BITS-1:0] s3_last_reg;
    logic [COUNT_BITS-1:0]    s3_count_reg;
    logic [TIME_BITS-1:0]     s3_peer_time_reg;
    logic [ESTIMATE_BITS-1:0] s3_peer_est_reg;
    logic [ESTIMATE_BITS-1:0] s3_peer_last_reg;
    logic [PB-1:0]            s3_t2_peer_reg;
    logic [PB-1:0]            s3_t3_peer_reg;
    logic [TIME_BITS-1:0]     s3_t3_peer_sat_reg;
    logic [TIME_BITS-1:0]     s3_time_next;
    logic [ESTIMATE_BITS-1:0] s3_est_next;
    logic [COUNT_BITS-1:0]    s3_count_next;
    logic [PB-1:0]            s2_t1_big;
    logic [PB-1:0]            s2_limit;

    always_comb
    begin
        s2_t1_big     = PB'(cfg.reset_time) * PB'(s2_big_reg);
        s2_limit      = PB'(cfg.interaction) * PB'(s2_big_reg);
        s3_time_next  = s2_resample_reg ? sat_prod(s2_t1_big) : s2_time_reg;
        s3_est_next   = s2_est_reg;
        s3_count_next = s2_count_reg;
        if (KW'(s2_count_reg) > KW'(s2_limit))
        begin
            s3_count_next = '0;
            if (DW'(s2_draw2_reg) > DW'(s2_est_reg))
            begin
                s3_est_next  = s2_draw2_est_reg;
                s3_time_next = sat_prod(s2_t1_draw2_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s3_time_reg        <= s3_time_next;
        s3_est_reg         <= s3_est_next;
        s3_last_reg        <= s2_last_reg;
        s3_count_reg       <= s3_count_next;
        s3_peer_time_reg   <= s2_peer_time_reg;
        s3_peer_est_reg    <= s2_peer_est_reg;
        s3_peer_last_reg   <= s2_peer_last_reg;
        s3_t2_peer_reg     <= s2_t2_peer_reg;
        s3_t3_peer_reg     <= s2_t3_peer_reg;
        s3_t3_peer_sat_reg <= s2_t3_peer_sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid              = s3_valid_reg;
    assign out_time               = s3_time_reg;
    assign out_estimate           = s3_est_reg;
    assign out_last_estimate      = s3_last_reg;
    assign out_count              = s3_count_reg;
    assign out_peer_time          = s3_peer_time_reg;
    assign out_peer_estimate      = s3_peer_est_reg;
    assign out_peer_last_estimate = s3_peer_last_reg;
    assign out_t2_peer            = s3_t2_peer_reg;
    assign out_t3_peer            = s3_t3_peer_reg;
    assign out_t3_peer_sat        = s3_t3_peer_sat_reg;

    // Either resample rule leaves the count cleared before the increment.
    a_resample_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_resample_reg) |=> (s3_count_reg == '0))
        else $error("resampled word kept a nonzero count");

endmodule

>>> rtl/core/sca_back.sv
// ----------------------------------------------------------------------------
// Size count agent transition back pipeline
// Three stages: the settled threshold of the new estimate, adoption of a
// larger peer estimate, and the merge with the final timer and count update.
// ----------------------------------------------------------------------------
module sca_back #(
    parameter int TIME_BITS     = sca_pkg::TIME_BITS_DEF,
    parameter int ESTIMATE_BITS = sca_pkg::ESTIMATE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sca_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    input  logic [TIME_BITS-1:0]                 in_time,
    input  logic [ESTIMATE_BITS-1:0]             in_estimate,
    input  logic [ESTIMATE_BITS-1:0]             in_last_estimate,
    input  logic [sca_pkg::COUNT_BITS-1:0]       in_count,
    input  logic [TIME_BITS-1:0]                 in_peer_time,
    input  logic [ESTIMATE_BITS-1:0]             in_peer_estimate,
    input  logic [ESTIMATE_BITS-1:0]             in_peer_last_estimate,
    input  logic [sca_pkg::MULT_BITS+ESTIMATE_BITS-1:0] in_t2_peer,
    input  logic [sca_pkg::MULT_BITS+ESTIMATE_BITS-1:0] in_t3_peer,
    input  logic [TIME_BITS-1:0]                 in_t3_peer_sat,
    output logic                                 done,
    output logic [TIME_BITS-1:0]                 out_time,
    output logic [ESTIMATE_BITS-1:0]             out_estimate,
    output logic [ESTIMATE_BITS-1:0]             out_last_estimate,
    output logic [sca_pkg::COUNT_BITS-1:0]       out_count
);
    import sca_pkg::*;

    localparam int PB = MULT_BITS + ESTIMATE_BITS;
    localparam int CW = ((TIME_BITS > PB) ? TIME_BITS : PB) + 2;
    localparam logic [TIME_BITS-1:0] TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

    function automatic logic signed [CW-1:0] sx_time(input logic [TIME_BITS-1:0] t);
        sx_time = {{(CW-TIME_BITS){t[TIME_BITS-1]}}, t};
    endfunction

    function automatic logic signed [CW-1:0] zx_prod(input logic [PB-1:0] p);
        zx_prod = {{(CW-PB){1'b0}}, p};
    endfunction

    // Stage 4.
    logic                     s4_valid_reg;
    logic [TIME_BITS-1:0]     s4_time_reg;
    logic [ESTIMATE_BITS-1:0] s4_est_reg;
    logic [ESTIMATE_BITS-1:0] s4_last_reg;
    logic [COUNT_BITS-1:0]    s4_count_reg;
    logic [TIME_BITS-1:0]     s4_peer_time_reg;
    logic [ESTIMATE_BITS-1:0] s4_peer_est_reg;
    logic [ESTIMATE_BITS-1:0] s4_peer_last_reg;
    logic [PB-1:0]            s4_t2_own_reg;
    logic [PB-1:0]            s4_t2_peer_reg;
    logic [PB-1:0]            s4_t3_peer_reg;
    logic [TIME_BITS-1:0]     s4_t3_peer_sat_reg;
    logic [PB-1:0]            s4_t2_own_next;

    assign s4_t2_own_next = PB'(cfg.healthy_time) * PB'(in_estimate);

    always_ff @(posedge clk)
    begin
        s4_time_reg        <= in_time;
        s4_est_reg         <= in_estimate;
        s4_last_reg        <= in_last_estimate;
        s4_count_reg       <= in_count;
        s4_peer_time_reg   <= in_peer_time;
        s4_peer_est_reg    <= in_peer_estimate;
        s4_peer_last_reg   <= in_peer_last_estimate;
        s4_t2_own_reg      <= s4_t2_own_next;
        s4_t2_peer_reg     <= in_t2_peer;
        s4_t3_peer_reg     <= in_t3_peer;
        s4_t3_peer_sat_reg <= in_t3_peer_sat;
    end

    // Stage 5.
    logic                     s5_valid_reg;
    logic [TIME_BITS-1:0]     s5_time_reg;
    logic [ESTIMATE_BITS-1:0] s5_est_reg;
    logic [ESTIMATE_BITS-1:0] s5_last_reg;
    logic [COUNT_BITS-1:0]    s5_count_reg;
    logic [TIME_BITS-1:0]     s5_peer_time_reg;
    logic [ESTIMATE_BITS-1:0] s5_peer_est_reg;
    logic [ESTIMATE_BITS-1:0] s5_peer_last_reg;
    logic [PB-1:0]            s5_t2_own_reg;
    logic [PB-1:0]            s5_t3_peer_reg;
    logic                     s4_adopt;
    logic [TIME_BITS-1:0]     s5_time_next;
    logic [ESTIMATE_BITS-1:0] s5_est_next;
    logic [PB-1:0]            s5_t2_own_next;

    always_comb
    begin
        s4_adopt = (sx_time(s4_time_reg) > zx_prod(s4_t2_own_reg))
            && (sx_time(s4_peer_time_reg) > zx_prod(s4_t2_peer_reg))
            && (s4_est_reg < s4_peer_est_reg);
        s5_time_next   = s4_adopt ? s4_t3_peer_sat_reg : s4_time_reg;
        s5_est_next    = s4_adopt ? s4_peer_est_reg : s4_est_reg;
        s5_t2_own_next = s4_adopt ? s4_t2_peer_reg : s4_t2_own_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_time_reg      <= s5_time_next;
        s5_est_reg       <= s5_est_next;
        s5_last_reg      <= s4_last_reg;
        s5_count_reg     <= s4_count_reg;
        s5_peer_time_reg <= s4_peer_time_reg;
        s5_peer_est_reg  <= s4_peer_est_reg;
        s5_peer_last_reg <= s4_peer_last_reg;
        s5_t2_own_reg    <= s5_t2_own_next;
        s5_t3_peer_reg   <= s4_t3_peer_reg;
    end

    // Stage 6.
    logic                     done_reg;
    logic [TIME_BITS-1:0]     out_time_reg;
    logic [ESTIMATE_BITS-1:0] out_est_reg;
    logic [ESTIMATE_BITS-1:0] out_last_reg;
    logic [COUNT_BITS-1:0]    out_count_reg;
    logic                     s5_merge;
    logic [TIME_BITS-1:0]     s5_time_max;
    logic [TIME_BITS-1:0]     out_time_next;
    logic [ESTIMATE_BITS-1:0] out_last_next;
    logic [COUNT_BITS-1:0]    out_count_next;

    always_comb
    begin
        s5_merge = (s5_est_reg == s5_peer_est_reg)
            && !((sx_time(s5_time_reg) > zx_prod(s5_t2_own_reg))
                && (sx_time(s5_peer_time_reg) < zx_prod(s5_t3_peer_reg)));
        out_last_next = (s5_merge && (s5_last_reg < s5_peer_last_reg))
            ? s5_peer_last_reg : s5_last_reg;
        s5_time_max = (sx_time(s5_time_reg) < sx_time(s5_peer_time_reg))
            ? s5_peer_time_reg : s5_time_reg;
        out_time_next  = (s5_time_max == TIME_MIN) ? TIME_MIN : s5_time_max - 1'b1;
        out_count_next = (&s5_count_reg) ? s5_count_reg : s5_count_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        out_time_reg  <= out_time_next;
        out_est_reg   <= s5_est_reg;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
            done_reg     <= s5_valid_reg;
        end
    end

    assign done              = done_reg;
    assign out_time          = out_time_reg;
    assign out_estimate      = out_est_reg;
    assign out_last_estimate = out_last_reg;
    assign out_count         = out_count_reg;

    // Every interaction counts itself, so a delivered count is never zero.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (out_count_reg != '0))
        else $error("delivered word has a zero interaction count");

endmodule

>>> rtl/core/size_count_agent_transition.sv
// ----------------------------------------------------------------------------
// Size count agent transition
// A word accepted while start is high passes through the six-stage pipeline
// with its multipliers and reaches the result ports, with done high, from
// the stage 6 registers. Throughput is one word per cycle; busy stays low
// and never holds the pipeline.
// Reset clears every valid bit and restores the register defaults.
// ----------------------------------------------------------------------------
module size_count_agent_transition #(
    parameter int TIME_BITS     = sca_pkg::TIME_BITS_DEF,
    parameter int ESTIMATE_BITS = sca_pkg::ESTIMATE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cfg_we,
    input  logic [sca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sca_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic signed [TIME_BITS-1:0]        own_time,
    input  logic [ESTIMATE_BITS-1:0]           own_estimate,
    input  logic [ESTIMATE_BITS-1:0]           own_last_estimate,
    input  logic [sca_pkg::COUNT_BITS-1:0]     own_count,
    input  logic signed [TIME_BITS-1:0]        peer_time,
    input  logic [ESTIMATE_BITS-1:0]           peer_estimate,
    input  logic [ESTIMATE_BITS-1:0]           peer_last_estimate,
    input  logic [sca_pkg::DRAW_BITS-1:0]      first_draw,
    input  logic [sca_pkg::DRAW_BITS-1:0]      second_draw,
    output logic                               done,
    output logic signed [TIME_BITS-1:0]        next_time,
    output logic [ESTIMATE_BITS-1:0]           next_estimate,
    output logic [ESTIMATE_BITS-1:0]           next_last_estimate,
    output logic [sca_pkg::COUNT_BITS-1:0]     next_count
);
    import sca_pkg::*;

    localparam int PB      = MULT_BITS + ESTIMATE_BITS;
    localparam int LATENCY = 6;

    cfg_t                     cfg;
    logic                     mid_valid;
    logic [TIME_BITS-1:0]     mid_time;
    logic [ESTIMATE_BITS-1:0] mid_estimate;
    logic [ESTIMATE_BITS-1:0] mid_last_estimate;
    logic [COUNT_BITS-1:0]    mid_count;
    logic [TIME_BITS-1:0]     mid_peer_time;
    logic [ESTIMATE_BITS-1:0] mid_peer_estimate;
    logic [ESTIMATE_BITS-1:0] mid_peer_last_estimate;
    logic [PB-1:0]            mid_t2_peer;
    logic [PB-1:0]            mid_t3_peer;
    logic [TIME_BITS-1:0]     mid_t3_peer_sat;
    logic [TIME_BITS-1:0]     res_time;
    logic                     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    sca_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sca_front #(
        .TIME_BITS     (TIME_BITS),
        .ESTIMATE_BITS (ESTIMATE_BITS)
    ) u_front (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg                    (cfg),
        .in_valid               (accept),
        .own_time               (own_time),
        .own_estimate           (own_estimate),
        .own_last_estimate      (own_last_estimate),
        .own_count              (own_count),
        .peer_time              (peer_time),
        .peer_estimate          (peer_estimate),
        .peer_last_estimate     (peer_last_estimate),
        .first_draw             (first_draw),
        .second_draw            (second_draw),
        .out_valid              (mid_valid),
        .out_time               (mid_time),
        .out_estimate           (mid_estimate),
        .out_last_estimate      (mid_last_estimate),
        .out_count              (mid_count),
        .out_peer_time          (mid_peer_time),
        .out_peer_estimate      (mid_peer_estimate),
        .out_peer_last_estimate (mid_peer_last_estimate),
        .out_t2_peer            (mid_t2_peer),
        .out_t3_peer            (mid_t3_peer),
        .out_t3_peer_sat        (mid_t3_peer_sat)
    );

    sca_back #(
        .TIME_BITS     (TIME_BITS),
        .ESTIMATE_BITS (ESTIMATE_BITS)
    ) u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg                   (cfg),
        .in_valid              (mid_valid),
        .in_time               (mid_time),
        .in_estimate           (mid_estimate),
        .in_last_estimate      (mid_last_estimate),
        .in_count              (mid_count),
        .in_peer_time          (mid_peer_time),
        .in_peer_estimate      (mid_peer_estimate),
        .in_peer_last_estimate (mid_peer_last_estimate),
        .in_t2_peer            (mid_t2_peer),
        .in_t3_peer            (mid_t3_peer),
        .in_t3_peer_sat        (mid_t3_peer_sat),
        .done                  (done),
        .out_time              (res_time),
        .out_estimate          (next_estimate),
        .out_last_estimate     (next_last_estimate),
        .out_count             (next_count)
    );

    assign next_time = res_time;

    // A result word only ever follows an accepted word by the full latency.
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result word without a matching accepted word");

endmodule
